// ----- hdl/gpw_pkg.sv -----
`default_nettype none

package gpw_pkg;

  localparam int COORD_W        = 10;
  localparam int TIME_W         = 16;
  localparam int CNT_W          = 16;
  localparam int TIME_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    HD_NORTH = 2'd0,
    HD_EAST  = 2'd1,
    HD_SOUTH = 2'd2,
    HD_WEST  = 2'd3
  } heading_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_NEIGHBOR = 2'd1,
    ST_HALTED       = 2'd2
  } status_e;

  typedef struct packed {
    logic               path_start;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] way_x;
    logic [COORD_W-1:0] way_y;
    heading_e           heading;
    logic [TIME_W-1:0]  way_time;
    logic               is_turn;
    logic [CNT_W-1:0]   distinct_count;
    status_e            status;
    logic               last_of_run;
  } out_t;

  // One queued job: the move (or error) beat, optionally preceded by a turn beat
  typedef struct packed {
    status_e            status;
    logic               has_turn;
    heading_e           heading;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;
    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  prev_time;
    logic [CNT_W-1:0]   count;
  } job_t;

endpackage

`default_nettype wire

// ----- hdl/gpw_front.sv -----
`default_nettype none

module gpw_front #(
  parameter int TIME_BITS = gpw_pkg::TIME_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire gpw_pkg::in_t in_data_i,
  output logic              push_o,
  output gpw_pkg::job_t     job_o,
  input  wire logic         full_i
);

  localparam int CW = gpw_pkg::COORD_W;
  localparam int NW = gpw_pkg::CNT_W;

  logic [CW-1:0]        last_x_q, last_x_d;
  logic [CW-1:0]        last_y_q, last_y_d;
  logic                 have_q, have_d;
  gpw_pkg::heading_e    hd_q, hd_d;
  logic [TIME_BITS-1:0] ltime_q, ltime_d;
  logic [TIME_BITS-1:0] step_q, step_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic                 halted_q, halted_d;

  logic                 accept;
  logic                 start;
  logic [CW-1:0]        eff_lx, eff_ly, cx, cy;
  logic                 eff_have, eff_halt;
  gpw_pkg::heading_e    eff_hd, new_hd;
  logic [TIME_BITS-1:0] eff_ltime, eff_step, step_inc;
  logic [NW-1:0]        eff_cnt, cnt_inc;
  logic                 go_n, go_e, go_s, go_w, same;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign start      = in_data_i.path_start;
  assign cx         = in_data_i.cell_x;
  assign cy         = in_data_i.cell_y;

  // A path start behaves as if the history were reset just before this beat
  always_comb begin
    eff_lx    = start ? '0 : last_x_q;
    eff_ly    = start ? '0 : last_y_q;
    eff_have  = start ? 1'b0 : have_q;
    eff_halt  = start ? 1'b0 : halted_q;
    eff_hd    = start ? gpw_pkg::HD_NORTH : hd_q;
    eff_ltime = start ? '0 : ltime_q;
    eff_step  = start ? '0 : step_q;
    eff_cnt   = start ? '0 : cnt_q;
    step_inc  = (eff_step == '1) ? eff_step : eff_step + 1'b1;
    cnt_inc   = (eff_cnt == '1) ? eff_cnt : eff_cnt + 1'b1;
  end

  // Neighbor tests one bit wider so the grid edge does not wrap
  always_comb begin
    same = (cx == eff_lx) && (cy == eff_ly);
    go_n = (cx == eff_lx) && ({1'b0, cy} == {1'b0, eff_ly} + 1'b1);
    go_e = (cy == eff_ly) && ({1'b0, cx} == {1'b0, eff_lx} + 1'b1);
    go_s = (cx == eff_lx) && ({1'b0, eff_ly} == {1'b0, cy} + 1'b1);
    go_w = (cy == eff_ly) && ({1'b0, eff_lx} == {1'b0, cx} + 1'b1);
    if (go_n) begin
      new_hd = gpw_pkg::HD_NORTH;
    end else if (go_e) begin
      new_hd = gpw_pkg::HD_EAST;
    end else if (go_s) begin
      new_hd = gpw_pkg::HD_SOUTH;
    end else begin
      new_hd = gpw_pkg::HD_WEST;
    end
  end

  always_comb begin
    last_x_d = eff_lx;
    last_y_d = eff_ly;
    have_d   = eff_have;
    hd_d     = eff_hd;
    ltime_d  = eff_ltime;
    step_d   = eff_step;
    cnt_d    = eff_cnt;
    halted_d = eff_halt;
    push_o   = 1'b0;

    job_o.status    = gpw_pkg::ST_OK;
    job_o.has_turn  = 1'b0;
    job_o.heading   = gpw_pkg::HD_NORTH;
    job_o.cur_x     = cx;
    job_o.cur_y     = cy;
    job_o.prev_x    = eff_lx;
    job_o.prev_y    = eff_ly;
    job_o.now_time  = '0;
    job_o.prev_time = gpw_pkg::TIME_W'(eff_ltime);
    job_o.count     = eff_cnt;

    if (eff_halt) begin
      push_o       = accept;
      job_o.status = gpw_pkg::ST_HALTED;
    end else if (!eff_have) begin
      push_o         = accept;
      job_o.heading  = gpw_pkg::HD_SOUTH;
      job_o.now_time = gpw_pkg::TIME_W'(eff_step);
      job_o.count    = cnt_inc;
      have_d         = 1'b1;
      hd_d           = gpw_pkg::HD_SOUTH;
      last_x_d       = cx;
      last_y_d       = cy;
      ltime_d        = eff_step;
      cnt_d          = cnt_inc;
      step_d         = step_inc;
    end else if (same) begin
      step_d = step_inc;
    end else if (!(go_n || go_e || go_s || go_w)) begin
      push_o       = accept;
      job_o.status = gpw_pkg::ST_NOT_NEIGHBOR;
      halted_d     = 1'b1;
    end else begin
      push_o         = accept;
      job_o.has_turn = (new_hd != eff_hd);
      job_o.heading  = new_hd;
      job_o.now_time = gpw_pkg::TIME_W'(eff_step);
      job_o.count    = cnt_inc;
      hd_d           = new_hd;
      last_x_d       = cx;
      last_y_d       = cy;
      ltime_d        = eff_step;
      cnt_d          = cnt_inc;
      step_d         = step_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
      have_q   <= 1'b0;
      hd_q     <= gpw_pkg::HD_NORTH;
      ltime_q  <= '0;
      step_q   <= '0;
      cnt_q    <= '0;
      halted_q <= 1'b0;
    end else if (accept) begin
      last_x_q <= last_x_d;
      last_y_q <= last_y_d;
      have_q   <= have_d;
      hd_q     <= hd_d;
      ltime_q  <= ltime_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gpw_queue.sv -----
`default_nettype none

module gpw_queue #(
  parameter int DEPTH = gpw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gpw_pkg::job_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  output gpw_pkg::job_t      head_o,
  input  wire logic          pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  gpw_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gpw_back.sv -----
`default_nettype none

module gpw_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire gpw_pkg::job_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gpw_pkg::out_t      out_data_o
);

  logic          out_valid_q, out_valid_d;
  logic          phase_q, phase_d;
  gpw_pkg::out_t out_data_q;
  gpw_pkg::out_t beat;
  logic          load, take, turn_beat;

  assign load      = !out_valid_q || !out_stall_i;
  assign take      = load && head_valid_i;
  assign turn_beat = head_i.has_turn && !phase_q;
  assign pop_o     = take && !turn_beat;

  always_comb begin
    beat.distinct_count = head_i.count;
    beat.heading        = head_i.heading;
    if (turn_beat) begin
      beat.way_x       = head_i.prev_x;
      beat.way_y       = head_i.prev_y;
      beat.way_time    = head_i.prev_time;
      beat.is_turn     = 1'b1;
      beat.status      = gpw_pkg::ST_OK;
      beat.last_of_run = 1'b0;
    end else begin
      beat.way_x       = head_i.cur_x;
      beat.way_y       = head_i.cur_y;
      beat.way_time    = head_i.now_time;
      beat.is_turn     = 1'b0;
      beat.status      = head_i.status;
      beat.last_of_run = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    if (take) begin
      out_valid_d = 1'b1;
      phase_d     = turn_beat;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/grid_path_to_heading_waypoints.sv -----
// The first result beat is registered in the job queue and then in the output register
// before it is presented. A job queue decouples input from output.
// Throughput: one input per cycle when it yields one result, the output is not stalled
// and the queue is not full; a heading change yields a turn beat and a move beat, which
// share the single output register. Repeated cells yield nothing.
// Reset (async, active low) clears the path history, counters and the halt flag.
`default_nettype none

module grid_path_to_heading_waypoints #(
  parameter int TIME_BITS   = gpw_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = gpw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire gpw_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gpw_pkg::out_t      out_data_o
);

  logic          push, full, head_valid, pop;
  gpw_pkg::job_t push_job, head_job;

  gpw_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (push_job),
    .full_i    (full)
  );

  gpw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .valid_o    (head_valid),
    .head_o     (head_job),
    .pop_i      (pop)
  );

  gpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_turn_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> out_data_o.is_turn)
    else $error("non-final beat is not a turn");

  a_move_follows_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("move beat did not follow turn beat");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != gpw_pkg::ST_OK) |->
      out_data_o.last_of_run && !out_data_o.is_turn)
    else $error("error beat must be a single final beat");
`endif

endmodule

`default_nettype wire
